[rtl/core/per_flow_departure_time_pacer_macros.svh]
// Assertion macros used by the pacer back end
`ifndef PER_FLOW_DEPARTURE_TIME_PACER_MACROS_SVH
`define PER_FLOW_DEPARTURE_TIME_PACER_MACROS_SVH

// same-cycle implication on clock, disabled in reset
`define PFDTP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clock, disabled in reset
`define PFDTP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pfdtp_pkg.sv]
// Types and constants of the per-flow departure time pacer
package pfdtp_pkg;

   localparam int FLOWS_DEFAULT = 1024;
   localparam int DIV_W         = 47;
   localparam int RATE_W        = 40;
   localparam logic [63:0] ONE_SECOND_NS    = 64'd1000000000;
   localparam logic [29:0] ONE_SECOND_NS_30 = 30'd1000000000;
   localparam logic [63:0] HORIZON_RESET    = 64'd2000000000;

   localparam logic CMD_PACKET   = 1'b0;
   localparam logic CMD_SET_RATE = 1'b1;

   localparam logic REG_HORIZON = 1'b0;

   typedef struct packed {
      logic        cmd;
      logic [9:0]  flow_index;
      logic [15:0] packet_length;
      logic [63:0] now_ns;
      logic        rate_enable;
      logic [39:0] new_byte_rate;
      logic [31:0] new_packet_rate;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic        depart_valid;
      logic [63:0] depart_time_ns;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        in_range;
      req_type     item;
   } head_type;

   typedef struct packed {
      logic        rate_present;
      logic        pacing_valid;
      logic [39:0] bytes_per_s;
      logic [31:0] pkts_per_s;
      logic [63:0] next_departure;
   } entry_type;

endpackage

[rtl/core/pfdtp_front.sv]
// Front end: accepts items into a two-entry queue and classifies the flow index
module pfdtp_front #(
   parameter int FLOWS = pfdtp_pkg::FLOWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pfdtp_pkg::req_type   req_data,
   input  logic                 pop,
   output pfdtp_pkg::head_type  head
);

   pfdtp_pkg::req_type q0_ff, q1_ff;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       push_head;

   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign push_head = push && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop));

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_head) begin
         q0_ff <= req_data;
      end else if (pop) begin
         q0_ff <= q1_ff;
      end
      if (push && !push_head) begin
         q1_ff <= req_data;
      end
   end

   always_comb begin
      head.valid    = (count_ff != 2'd0);
      head.in_range = ({22'd0, q0_ff.flow_index} < 32'(FLOWS));
      head.item     = q0_ff;
   end

endmodule

[rtl/core/pfdtp_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle; zero divisor gives zero
module pfdtp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pfdtp_pkg::DIV_W-1:0]  dividend,
   input  logic [pfdtp_pkg::RATE_W-1:0] divisor,
   output logic                         done,
   output logic [pfdtp_pkg::DIV_W-1:0]  quotient
);

   localparam int DW = pfdtp_pkg::DIV_W;
   localparam int RW = pfdtp_pkg::RATE_W;

   logic [RW:0]   rem_ff;
   logic [DW-1:0] quo_ff;
   logic [RW-1:0] dvs_ff;
   logic [5:0]    cnt_ff;
   logic          run_ff, done_ff, zero_ff;
   logic [RW:0]   shifted;
   logic [RW+1:0] diff;

   always_comb begin
      shifted = {rem_ff[RW-1:0], quo_ff[DW-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == 6'(DW - 1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DW - 1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dvs_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (run_ff) begin
         if (!diff[RW+1]) begin
            rem_ff <= diff[RW:0];
         end else begin
            rem_ff <= shifted;
         end
         quo_ff <= {quo_ff[DW-2:0], !diff[RW+1]};
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

endmodule

[rtl/core/pfdtp_back.sv]
// Back end: flow table, delay computation, departure decision and result register
`include "per_flow_departure_time_pacer_macros.svh"

module pfdtp_back #(
   parameter int FLOWS = pfdtp_pkg::FLOWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfdtp_pkg::head_type  head,
   output logic                 pop,
   input  logic [63:0]          horizon,
   output logic                 rsp_valid,
   output pfdtp_pkg::rsp_type   rsp_data
);

   localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int DW = pfdtp_pkg::DIV_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   pfdtp_pkg::entry_type mem [FLOWS];

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff;
   pfdtp_pkg::req_type   item_ff;
   pfdtp_pkg::entry_type rd_q_ff, ent_ff, wr_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [DW-1:0]        prod_ff;
   logic                 div_start;
   logic [DW-1:0]        byte_dvd, pkt_dvd, byte_q, pkt_q;
   logic                 byte_done, pkt_done;
   logic                 out_valid_ff, out_valid_in;
   pfdtp_pkg::rsp_type   out_data_ff, out_data_in;
   logic [63:0]          delay, now, limit;

   assign rd_addr   = AW'(head.item.flow_index);
   assign byte_dvd  = prod_ff + DW'(ent_ff.bytes_per_s >> 1);
   assign pkt_dvd   = DW'(pfdtp_pkg::ONE_SECOND_NS) + DW'(ent_ff.pkts_per_s >> 1);
   assign div_start = (state_ff == ST_LOAD);

   pfdtp_div u_div_byte (
      .clock(clock), .reset(reset), .start(div_start), .dividend(byte_dvd),
      .divisor(ent_ff.bytes_per_s), .done(byte_done), .quotient(byte_q)
   );

   pfdtp_div u_div_pkt (
      .clock(clock), .reset(reset), .start(div_start), .dividend(pkt_dvd),
      .divisor({8'd0, ent_ff.pkts_per_s}), .done(pkt_done), .quotient(pkt_q)
   );

   always_comb begin
      now   = item_ff.now_ns;
      limit = now + horizon;
      delay = (pkt_q > byte_q) ? 64'(pkt_q) : 64'(byte_q);
   end

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(item_ff.flow_index);
      wr_data      = rd_q_ff;
      out_valid_in = 1'b0;
      out_data_in  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == AW'(FLOWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.in_range) begin
                  state_in = ST_READ;
               end else begin
                  out_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            if (item_ff.cmd == pfdtp_pkg::CMD_SET_RATE) begin
               wr_en                = 1'b1;
               wr_data.rate_present = item_ff.rate_enable;
               if (item_ff.rate_enable) begin
                  wr_data.bytes_per_s = item_ff.new_byte_rate;
                  wr_data.pkts_per_s  = item_ff.new_packet_rate;
               end
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!rd_q_ff.rate_present) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (byte_done && pkt_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
            wr_data      = ent_ff;
            if (!ent_ff.pacing_valid || (ent_ff.next_departure < now)) begin
               wr_en                     = 1'b1;
               wr_data.pacing_valid      = 1'b1;
               wr_data.next_departure    = now + delay;
               out_data_in.depart_valid  = 1'b1;
               out_data_in.depart_time_ns = now;
            end else if (ent_ff.next_departure > limit) begin
               out_data_in.verdict = 1'b1;
            end else begin
               wr_en                      = 1'b1;
               wr_data.next_departure     = ent_ff.next_departure + delay;
               out_data_in.depart_valid   = 1'b1;
               out_data_in.depart_time_ns = ent_ff.next_departure;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (pop) begin
         item_ff <= head.item;
      end
      if (state_ff == ST_READ) begin
         ent_ff  <= rd_q_ff;
         prod_ff <= DW'(item_ff.packet_length) * DW'(pfdtp_pkg::ONE_SECOND_NS_30);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `PFDTP_ASSERT_IMP(a_wait_quiet, state_ff == ST_WAIT, !pop && !out_valid_in, "early item")
   `PFDTP_ASSERT_IMP(a_drop, rsp_valid && rsp_data.verdict, !rsp_data.depart_valid, "drop timed")
   `PFDTP_ASSERT_IMP(a_clear_quiet, state_ff == ST_CLEAR, !pop && !out_valid_in, "item in clear")
   `PFDTP_ASSERT_NXT(a_div_done, state_ff == ST_WAIT && byte_done, state_ff == ST_DECIDE, "late")

endmodule

[rtl/core/per_flow_departure_time_pacer.sv]
// Top level of the per-flow departure time pacer
//
// Items arrive on req_data and are taken when start is high and busy is low.
// cmd 0 is a packet: the flow's byte and packet rates give two rounded delays,
// the larger one paces the flow, and the result carries a pass or drop verdict
// and the departure time. cmd 1 installs or removes the flow's rate entry.
// Every item gives exactly one result, shown on rsp_data for one cycle with
// rsp_valid high; the receiver cannot stall.
// A paced packet waits for the two 47-step radix-2 dividers working side by side.
// Items are processed one at a time; a two-entry queue absorbs arrivals.
// After reset the flow table is cleared one entry a cycle, while items queue
// but are not processed. The drop horizon register (offset 0, 64 bits) resets
// to two seconds and is written over the APB-style port.
module per_flow_departure_time_pacer #(
   parameter int FLOWS = pfdtp_pkg::FLOWS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pfdtp_pkg::req_type  req_data,
   output logic                rsp_valid,
   output pfdtp_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready
);

   logic [63:0]         horizon_ff;
   pfdtp_pkg::head_type head;
   logic                pop;

   assign pready = 1'b1;
   assign prdata = (paddr[3] == pfdtp_pkg::REG_HORIZON) ? horizon_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= pfdtp_pkg::HORIZON_RESET;
      end else if (psel && penable && pwrite && (paddr[3] == pfdtp_pkg::REG_HORIZON)) begin
         horizon_ff <= pwdata;
      end
   end

   pfdtp_front #(.FLOWS(FLOWS)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .pop(pop), .head(head)
   );

   pfdtp_back #(.FLOWS(FLOWS)) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop), .horizon(horizon_ff),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule
